@@ design/smp_pkg.sv @@
// Shared constants, register codes and types for the score map peak finder.
`timescale 1ns / 1ps

package smp_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 4096;

  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int X_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = 13;
  localparam int Y_W     = $clog2(MAX_ROWS);
  localparam int NC_W    = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
  localparam int RING_AW = $clog2(2 * MAX_COLUMNS);
  localparam int RING_DEPTH = 1 << RING_AW;

  localparam int SCORE_W = 32;
  localparam int SIZE_W  = 16;
  localparam int WORD_W  = SCORE_W + SIZE_W;
  localparam int PCOL_W  = 7;
  localparam int PROW_W  = 12;
  localparam int DIFF_W  = 14;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLUMNS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

  localparam logic KIND_CELL = 1'b0;

  typedef struct packed {
    logic signed [31:0] score_threshold;
    logic [7:0]         map_columns;
    logic [12:0]        map_rows;
    logic [19:0]        level_scale;
    logic [7:0]         pad_columns;
    logic [7:0]         pad_rows;
    logic [15:0]        image_width;
    logic [15:0]        image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    score_threshold: 32'sd0,
    map_columns:     8'd128,
    map_rows:        13'd64,
    level_scale:     20'd1024,
    pad_columns:     8'd12,
    pad_rows:        8'd12,
    image_width:     16'd640,
    image_height:    16'd480
  };

  // One queued step for the back end.
  typedef struct packed {
    logic                      write;
    logic                      decide;
    logic                      prime;
    logic signed [SCORE_W-1:0] score;
    logic [7:0]                root_width;
    logic [7:0]                root_height;
    logic [RING_AW-1:0]        waddr;
    logic [RING_AW-1:0]        raddr_mid;
    logic [RING_AW-1:0]        raddr_up;
    logic [X_W-1:0]            col;
    logic [Y_W-1:0]            row;
    logic                      left_ok;
    logic                      right_ok;
    logic                      up_ok;
    logic                      down_ok;
    logic                      frame_done;
  } tok_t;

endpackage

@@ design/smp_ram.sv @@
// Generic RAM: one write port, two registered read ports, read-first.
`timescale 1ns / 1ps

module smp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ design/smp_front.sv @@
// Front end: accepts words, tracks frame position and classifies each step.
`timescale 1ns / 1ps

module smp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  smp_pkg::cfg_t              cfg,
  input  logic                       restart,
  input  logic                       acc,
  input  logic                       kind,
  input  logic signed [31:0]         cell_score,
  input  logic [7:0]                 root_width,
  input  logic [7:0]                 root_height,
  output logic                       push,
  output smp_pkg::tok_t              tok
);
  import smp_pkg::*;

  logic [NC_W-1:0]  cells_in;
  logic [NC_W-1:0]  dnext;
  logic [X_W-1:0]   col;
  logic [Y_W-1:0]   row;

  logic [COL_W-1:0] cols;
  logic [ROW_W-1:0] rows;
  logic [NC_W-1:0]  ncells;
  logic [NC_W:0]    lag;
  logic [NC_W-1:0]  ci1;
  logic             is_cell;
  logic             drain_dec;
  logic             dec;
  logic             prime;
  logic             fd;
  logic             last_col;
  logic [RING_AW-1:0] mid;

  always_comb begin
    if (cfg.map_columns < 8'd3) begin
      cols = COL_W'(3);
    end else if (int'(cfg.map_columns) > MAX_COLUMNS) begin
      cols = COL_W'(MAX_COLUMNS);
    end else begin
      cols = COL_W'(cfg.map_columns);
    end
    if (cfg.map_rows == '0) begin
      rows = ROW_W'(1);
    end else if (int'(cfg.map_rows) > MAX_ROWS) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = cfg.map_rows;
    end
    ncells = NC_W'(rows) * NC_W'(cols);
    // a single-row map decides as soon as its last cell is in
    lag = (rows == ROW_W'(1)) ? (NC_W+1)'(cols) : (NC_W+1)'(cols) + (NC_W+1)'(2);

    ci1       = cells_in + NC_W'(1);
    is_cell   = (kind == KIND_CELL) && (cells_in < ncells);
    drain_dec = !is_cell && (cells_in == ncells) && (dnext < ncells);
    if (is_cell) begin
      dec = (ci1 == ncells) || ({1'b0, ci1} >= ({1'b0, dnext} + lag));
    end else begin
      dec = drain_dec;
    end
    prime    = is_cell && ({1'b0, ci1} == lag - (NC_W+1)'(1));
    fd       = dec && (dnext + NC_W'(1) == ncells);
    last_col = (COL_W'(col) + COL_W'(1)) >= cols;
    push     = acc && (is_cell || drain_dec);

    mid = dec ? RING_AW'(dnext + NC_W'(1)) : RING_AW'(dnext);

    tok.write       = is_cell;
    tok.decide      = dec;
    tok.prime       = prime;
    tok.score       = cell_score;
    tok.root_width  = root_width;
    tok.root_height = root_height;
    tok.waddr       = RING_AW'(cells_in);
    tok.raddr_mid   = mid;
    tok.raddr_up    = mid - RING_AW'(cols);
    tok.col         = col;
    tok.row         = row;
    tok.left_ok     = (col != '0);
    tok.right_ok    = !last_col;
    tok.up_ok       = (row != '0);
    tok.down_ok     = (ROW_W'(row) + ROW_W'(1)) < rows;
    tok.frame_done  = fd;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cells_in <= '0;
      dnext    <= '0;
      col      <= '0;
      row      <= '0;
    end else if (acc) begin
      if (fd) begin
        cells_in <= '0;
        dnext    <= '0;
        col      <= '0;
        row      <= '0;
      end else begin
        if (is_cell) begin
          cells_in <= ci1;
        end
        if (dec) begin
          dnext <= dnext + NC_W'(1);
          if (last_col) begin
            col <= '0;
            row <= row + Y_W'(1);
          end else begin
            col <= col + X_W'(1);
          end
        end
      end
    end
  end

endmodule

@@ design/smp_queue.sv @@
// Short step queue between the front and back ends.
`timescale 1ns / 1ps

module smp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smp_pkg::tok_t tok_in,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output smp_pkg::tok_t tok_out
);
  import smp_pkg::*;

  tok_t             slots [QUEUE_DEPTH];
  logic [Q_AW-1:0]  wptr;
  logic [Q_AW-1:0]  rptr;
  logic [Q_CW-1:0]  count;
  logic             do_pop;

  assign full      = (count == Q_CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign tok_out   = slots[rptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      if (push && !do_pop) begin
        count <= count + Q_CW'(1);
      end else if (!push && do_pop) begin
        count <= count - Q_CW'(1);
      end
    end
  end

endmodule

@@ design/smp_back.sv @@
// Back end: line store, sliding 3x3 window, peak test and box arithmetic.
`timescale 1ns / 1ps

module smp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  smp_pkg::cfg_t        cfg,
  input  logic                 q_valid,
  input  smp_pkg::tok_t        tok,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 found,
  output logic [6:0]           peak_column,
  output logic [11:0]          peak_row,
  output logic signed [31:0]   peak_score,
  output logic [15:0]          box_left,
  output logic [15:0]          box_top,
  output logic [15:0]          box_width,
  output logic [15:0]          box_height,
  output logic                 frame_done
);
  import smp_pkg::*;

  logic en;
  logic take;
  logic fetch;
  logic [WORD_W-1:0] rd_mid;
  logic [WORD_W-1:0] rd_up;

  assign en    = !out_valid || out_ready;
  assign take  = en && q_valid;
  assign pop   = take;
  assign fetch = tok.decide || tok.prime;

  smp_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_lines (
    .clk     (clk),
    .we      (take && tok.write),
    .waddr   (tok.waddr),
    .wdata   ({tok.score, tok.root_width, tok.root_height}),
    .re      (take && fetch),
    .raddr_a (tok.raddr_mid),
    .raddr_b (tok.raddr_up),
    .rdata_a (rd_mid),
    .rdata_b (rd_up)
  );

  // stage 1: store read in flight
  logic                      s1_valid;
  logic                      s1_decide;
  logic signed [SCORE_W-1:0] s1_newest;
  logic                      s1_lv, s1_rv, s1_uv, s1_dv;
  logic [X_W-1:0]            s1_col;
  logic [Y_W-1:0]            s1_row;
  logic                      s1_fd;

  // window: up, mid, down rows; index 1 left, 2 center; the right column is ru, rm, rdn
  logic signed [SCORE_W-1:0] u1, u2, m1, m2, d1, d2;
  logic [SIZE_W-1:0]         sz2;
  logic signed [SCORE_W-1:0] ru, rm, rdn, c;
  logic                      peak;

  // stage 2: peak decision
  logic                      s2_valid;
  logic                      s2_peak;
  logic signed [SCORE_W-1:0] s2_score;
  logic [SIZE_W-1:0]         s2_size;
  logic [X_W-1:0]            s2_col;
  logic [Y_W-1:0]            s2_row;
  logic                      s2_fd;

  // stage 3: products
  logic                      s3_valid;
  logic                      s3_peak;
  logic signed [SCORE_W-1:0] s3_score;
  logic [X_W-1:0]            s3_col;
  logic [Y_W-1:0]            s3_row;
  logic                      s3_fd;
  logic signed [34:0]        s3_px, s3_py;
  logic [27:0]               s3_pw, s3_ph;
  logic signed [DIFF_W-1:0]  dx, dy;

  // stage 4: rounded box
  logic                      s4_valid;
  logic                      s4_peak;
  logic signed [SCORE_W-1:0] s4_score;
  logic [X_W-1:0]            s4_col;
  logic [Y_W-1:0]            s4_row;
  logic                      s4_fd;
  logic [26:0]               s4_l, s4_t;
  logic [20:0]               s4_w, s4_h;

  logic signed [28:0]        room_w, room_h, wv, hv, wf, hf;
  logic                      hit;

  always_comb begin
    ru  = rd_up[WORD_W-1:SIZE_W];
    rm  = rd_mid[WORD_W-1:SIZE_W];
    rdn = s1_newest;
    c   = m2;
    // neighbors outside the map drop out of the test
    peak = (c > cfg.score_threshold)
        && (!(s1_uv && s1_lv) || (c > u1))
        && (!s1_lv || (c > m1))
        && (!(s1_dv && s1_lv) || (c > d1))
        && (!s1_uv || (c > u2))
        && (!s1_dv || (c > d2))
        && (!(s1_uv && s1_rv) || (c > ru))
        && (!s1_rv || (c > rm))
        && (!(s1_dv && s1_rv) || (c > rdn));

    dx = DIFF_W'(s2_col) - DIFF_W'(cfg.pad_columns);
    dy = DIFF_W'(s2_row) - DIFF_W'(cfg.pad_rows);

    room_w = $signed({13'b0, cfg.image_width}) - $signed({2'b0, s4_l});
    room_h = $signed({13'b0, cfg.image_height}) - $signed({2'b0, s4_t});
    wv     = $signed({8'b0, s4_w});
    hv     = $signed({8'b0, s4_h});
    wf     = (wv > room_w) ? room_w : wv;
    hf     = (hv > room_h) ? room_h : hv;
    hit    = s4_peak && (wf > 29'sd0) && (hf > 29'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= take && fetch;
      s2_valid  <= s1_valid && s1_decide;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_decide <= tok.decide;
      s1_newest <= tok.score;
      s1_lv     <= tok.left_ok;
      s1_rv     <= tok.right_ok;
      s1_uv     <= tok.up_ok;
      s1_dv     <= tok.down_ok;
      s1_col    <= tok.col;
      s1_row    <= tok.row;
      s1_fd     <= tok.frame_done;

      if (s1_valid) begin
        // advance the window one column
        u1  <= u2;
        m1  <= m2;
        d1  <= d2;
        u2  <= ru;
        m2  <= rm;
        d2  <= rdn;
        sz2 <= rd_mid[SIZE_W-1:0];
      end

      s2_peak  <= peak;
      s2_score <= m2;
      s2_size  <= sz2;
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_fd    <= s1_fd;

      s3_peak  <= s2_peak;
      s3_score <= s2_score;
      s3_col   <= s2_col;
      s3_row   <= s2_row;
      s3_fd    <= s2_fd;
      s3_px    <= dx * $signed({1'b0, cfg.level_scale});
      s3_py    <= dy * $signed({1'b0, cfg.level_scale});
      s3_pw    <= s2_size[15:8] * cfg.level_scale;
      s3_ph    <= s2_size[7:0] * cfg.level_scale;

      s4_peak  <= s3_peak;
      s4_score <= s3_score;
      s4_col   <= s3_col;
      s4_row   <= s3_row;
      s4_fd    <= s3_fd;
      s4_l     <= s3_px[34] ? '0 : 27'((s3_px + 35'sd128) >>> 8);
      s4_t     <= s3_py[34] ? '0 : 27'((s3_py + 35'sd128) >>> 8);
      s4_w     <= 21'((s3_pw + 28'd128) >> 8);
      s4_h     <= 21'((s3_ph + 28'd128) >> 8);

      found       <= hit;
      peak_column <= PCOL_W'(s4_col);
      peak_row    <= PROW_W'(s4_row);
      peak_score  <= s4_score;
      box_left    <= hit ? s4_l[15:0] : '0;
      box_top     <= hit ? s4_t[15:0] : '0;
      box_width   <= hit ? wf[15:0] : '0;
      box_height  <= hit ? hf[15:0] : '0;
      frame_done  <= s4_fd;
    end
  end

endmodule

@@ design/score_map_peak_box_finder_top.sv @@
// Top level of the score map peak finder: config registers, front, queue, back.
`timescale 1ns / 1ps

// Score cells enter in raster order on in_valid/in_ready (kind 0 = cell,
// kind 1 = drain step). After the final cell of a map, map_columns+1 drain
// words (map_columns taken as clamped to 3..128) flush the last decisions.
// Each decided cell gives one result word on out_valid/out_ready; found marks
// a peak with a non-empty box, and frame_done marks the last cell of the map.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data while the
// block is idle; a write to map_columns or map_rows restarts the frame.
// Throughput: one word per cycle while the queue has room and the receiver
// does not stall, set by the single write port of the line store and the
// one-column window advance per decision.
// A result word is registered through queue, store read, peak test, multiply,
// round and clip, one register each, after the word triggering it is accepted.
// The receiver can stall freely: the back end holds, and the 4-entry step
// queue keeps in_ready high until it fills.
// Reset (synchronous, rst high) restores register defaults, clears the frame
// position and empties the pipeline. The line store needs no clearing.

module score_map_peak_box_finder_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic signed [31:0]   cell_score,
  input  logic [7:0]           root_width,
  input  logic [7:0]           root_height,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 found,
  output logic [6:0]           peak_column,
  output logic [11:0]          peak_row,
  output logic signed [31:0]   peak_score,
  output logic [15:0]          box_left,
  output logic [15:0]          box_top,
  output logic [15:0]          box_width,
  output logic [15:0]          box_height,
  output logic                 frame_done
);
  import smp_pkg::*;

  cfg_t  cfg;
  logic  cfg_we;
  logic  restart;
  logic  acc;
  logic  push;
  tok_t  tok_in;
  tok_t  tok_out;
  logic  q_full;
  logic  q_valid;
  logic  pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we &&
                     ((cfg_index == REG_MAP_COLUMNS) || (cfg_index == REG_MAP_ROWS));
  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:    cfg.score_threshold <= $signed(cfg_data);
        REG_MAP_COLUMNS:  cfg.map_columns     <= cfg_data[7:0];
        REG_MAP_ROWS:     cfg.map_rows        <= cfg_data[12:0];
        REG_LEVEL_SCALE:  cfg.level_scale     <= cfg_data[19:0];
        REG_PAD_COLUMNS:  cfg.pad_columns     <= cfg_data[7:0];
        REG_PAD_ROWS:     cfg.pad_rows        <= cfg_data[7:0];
        REG_IMAGE_WIDTH:  cfg.image_width     <= cfg_data[15:0];
        REG_IMAGE_HEIGHT: cfg.image_height    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  smp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .acc         (acc),
    .kind        (kind),
    .cell_score  (cell_score),
    .root_width  (root_width),
    .root_height (root_height),
    .push        (push),
    .tok         (tok_in)
  );

  smp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .tok_in    (tok_in),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .tok_out   (tok_out)
  );

  smp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .tok         (tok_out),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .peak_column (peak_column),
    .peak_row    (peak_row),
    .peak_score  (peak_score),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_width   (box_width),
    .box_height  (box_height),
    .frame_done  (frame_done)
  );

  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (box_width == '0) && (box_height == '0)
      && (box_left == '0) && (box_top == '0))
    else $error("box fields not cleared on a non-peak word");

  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (box_width != '0) && (box_height != '0))
    else $error("peak reported with an empty box");

  a_box_in_image: assert property (@(posedge clk) disable iff (rst)
    out_valid && found && !cfg_we |->
      ({1'b0, box_left} + {1'b0, box_width}) <= {1'b0, cfg.image_width})
    else $error("box runs past the image right edge");

endmodule

@@ tb/smp_peak_checker.sv @@
// Checker for the score map peak finder: predicts each decision and compares results.
`timescale 1ns / 1ps

module smp_peak_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] cell_score,
  input  logic [7:0]         root_width,
  input  logic [7:0]         root_height,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               found,
  input  logic [6:0]         peak_column,
  input  logic [11:0]        peak_row,
  input  logic signed [31:0] peak_score,
  input  logic [15:0]        box_left,
  input  logic [15:0]        box_top,
  input  logic [15:0]        box_width,
  input  logic [15:0]        box_height,
  input  logic               frame_done,
  output int                 mismatches,
  output int                 awaiting,
  output int                 decisions,
  output int                 peaks
);
  import smp_pkg::*;

  localparam int SCORE_SLOTS = 2 * MAX_COLUMNS + 4;
  localparam int SIZE_SLOTS  = MAX_COLUMNS + 2;

  typedef struct {
    logic               found;
    logic [6:0]         col;
    logic [11:0]        row;
    logic signed [31:0] score;
    logic [15:0]        left;
    logic [15:0]        top;
    logic [15:0]        width;
    logic [15:0]        height;
    logic               done;
  } peak_word_t;

  cfg_t               regs;
  logic signed [31:0] score_hist [SCORE_SLOTS];
  logic [15:0]        size_hist [SIZE_SLOTS];
  int unsigned        col_pos, row_pos, cells_taken;
  peak_word_t         expected_peaks [$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
    decisions  = 0;
    peaks      = 0;
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned active_cols();
    if (regs.map_columns < 3) return 3;
    if (regs.map_columns > MAX_COLUMNS) return MAX_COLUMNS;
    return regs.map_columns;
  endfunction

  function automatic int unsigned active_rows();
    if (regs.map_rows < 1) return 1;
    if (regs.map_rows > MAX_ROWS) return MAX_ROWS;
    return regs.map_rows;
  endfunction

  // Cells to pixels, Q.8 rounded; negative positions clamp at zero.
  function automatic longint to_pixels(input longint cells);
    longint v;
    v = cells * longint'(regs.level_scale);
    if (v < 0) return 0;
    return (v + 128) >>> 8;
  endfunction

  function automatic peak_word_t judge_cell();
    peak_word_t         r;
    int unsigned        cols, rows, d;
    logic signed [31:0] s, nb;
    logic               is_peak;
    longint             ny, nx, l, t, w, h;
    logic [15:0]        sz;
    cols = active_cols();
    rows = active_rows();
    d = row_pos * cols + col_pos;
    s = score_hist[d % SCORE_SLOTS];
    is_peak = s > regs.score_threshold;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        ny = longint'(row_pos) + dy;
        nx = longint'(col_pos) + dx;
        if (ny < 0 || nx < 0 || ny >= rows || nx >= cols || (dy == 0 && dx == 0)) continue;
        nb = score_hist[(ny * cols + nx) % SCORE_SLOTS];
        if (!(s > nb)) is_peak = 1'b0;
      end
    end
    r = '{default: '0};
    if (is_peak) begin
      sz = size_hist[d % SIZE_SLOTS];
      l = to_pixels(longint'(col_pos) - longint'(regs.pad_columns));
      t = to_pixels(longint'(row_pos) - longint'(regs.pad_rows));
      w = to_pixels(longint'(sz[15:8]));
      h = to_pixels(longint'(sz[7:0]));
      if (w > longint'(regs.image_width) - l) w = longint'(regs.image_width) - l;
      if (h > longint'(regs.image_height) - t) h = longint'(regs.image_height) - t;
      if (w > 0 && h > 0) begin
        r.found  = 1'b1;
        r.left   = l[15:0];
        r.top    = t[15:0];
        r.width  = w[15:0];
        r.height = h[15:0];
      end
    end
    r.col   = col_pos[6:0];
    r.row   = row_pos[11:0];
    r.score = s;
    r.done  = (d + 1 == rows * cols);
    if (r.done) begin
      col_pos = 0;
      row_pos = 0;
      cells_taken = 0;
    end else if (col_pos + 1 >= cols) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  // Returns 1 when the word triggers a decision.
  function automatic bit take_word(output peak_word_t r);
    int unsigned cols, ncells, dnext;
    cols = active_cols();
    ncells = active_rows() * cols;
    dnext = row_pos * cols + col_pos;
    if (kind == KIND_CELL && cells_taken < ncells) begin
      score_hist[cells_taken % SCORE_SLOTS] = cell_score;
      size_hist[cells_taken % SIZE_SLOTS] = {root_width, root_height};
      cells_taken++;
      if (cells_taken == ncells || cells_taken >= dnext + cols + 2) begin
        r = judge_cell();
        return 1;
      end
      return 0;
    end
    if (cells_taken == ncells && dnext < ncells) begin
      r = judge_cell();
      return 1;
    end
    return 0;
  endfunction

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    peak_word_t want;
    peak_word_t next;
    if (rst) begin
      regs = CFG_RESET;
      col_pos = 0;
      row_pos = 0;
      cells_taken = 0;
      expected_peaks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_peaks.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = expected_peaks.pop_front();
          decisions++;
          if (found === 1'b1) peaks++;
          if ($isunknown({found, peak_column, peak_row, peak_score, box_left, box_top,
                          box_width, box_height, frame_done}))
            report("unknown bits on result word");
          check_field("found", found, want.found);
          check_field("peak_column", peak_column, want.col);
          check_field("peak_row", peak_row, want.row);
          check_field("peak_score", peak_score, want.score);
          check_field("box_left", box_left, want.left);
          check_field("box_top", box_top, want.top);
          check_field("box_width", box_width, want.width);
          check_field("box_height", box_height, want.height);
          check_field("frame_done", frame_done, want.done);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:    regs.score_threshold = cfg_data;
          REG_MAP_COLUMNS: begin
            regs.map_columns = cfg_data[7:0];
            col_pos = 0;
            row_pos = 0;
            cells_taken = 0;
          end
          REG_MAP_ROWS: begin
            regs.map_rows = cfg_data[12:0];
            col_pos = 0;
            row_pos = 0;
            cells_taken = 0;
          end
          REG_LEVEL_SCALE:  regs.level_scale = cfg_data[19:0];
          REG_PAD_COLUMNS:  regs.pad_columns = cfg_data[7:0];
          REG_PAD_ROWS:     regs.pad_rows = cfg_data[7:0];
          REG_IMAGE_WIDTH:  regs.image_width = cfg_data[15:0];
          REG_IMAGE_HEIGHT: regs.image_height = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (take_word(next)) expected_peaks = {expected_peaks, next};
      end
    end
    awaiting <= expected_peaks.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the score map peak finder: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
  import smp_pkg::*;

  localparam logic KIND_DRAIN = 1'b1;
  localparam int   ITEM_GOAL  = 1300;
  localparam int   SETTLE     = 16;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic signed [31:0] cell_score;
  logic [7:0]         root_width;
  logic [7:0]         root_height;
  logic               out_valid;
  logic               out_ready;
  logic               found;
  logic [6:0]         peak_column;
  logic [11:0]        peak_row;
  logic signed [31:0] peak_score;
  logic [15:0]        box_left;
  logic [15:0]        box_top;
  logic [15:0]        box_width;
  logic [15:0]        box_height;
  logic               frame_done;

  int mismatches, awaiting, decisions, peaks;
  int words_sent, burst_left, frames_run;
  int stall_mode, cycle_no;

  score_map_peak_box_finder_top dut (.*);

  smp_peak_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever begin
      #2 clk = 1'b1;
      #2 clk = 1'b0;
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d results still expected", awaiting);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver stalls: the stall pattern is redrawn periodically from four modes.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((cycle_no % 16) < 11);
      default: out_ready <= ((cycle_no / 37) % 2 == 0);
    endcase
  end

  task automatic send_word(input logic k, input logic [31:0] s, input logic [7:0] w,
                           input logic [7:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    kind        <= k;
    cell_score  <= s;
    root_width  <= w;
    root_height <= h;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_geometry(input logic [31:0] thr, input int cols, input int rows,
                               input int scale, input int padc, input int padr,
                               input int imw, input int imh);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MAP_COLUMNS, cols);
    write_reg(REG_MAP_ROWS, rows);
    write_reg(REG_LEVEL_SCALE, scale);
    write_reg(REG_PAD_COLUMNS, padc);
    write_reg(REG_PAD_ROWS, padr);
    write_reg(REG_IMAGE_WIDTH, imw);
    write_reg(REG_IMAGE_HEIGHT, imh);
  endtask

  function automatic logic [31:0] pick_score();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 200)) - 100 <<< 12;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // One map: optional early drain, cells in raster order, flush, optional stray drain.
  task automatic run_frame(input int cols, input int rows, input int cells_cap);
    int ncells;
    ncells = cols * rows;
    if (cells_cap < ncells) ncells = cells_cap;
    if ($urandom_range(0, 3) == 0) send_word(KIND_DRAIN, $urandom, rand_byte(), rand_byte());
    for (int i = 0; i < ncells; i++) begin
      send_word(KIND_CELL, pick_score(), rand_byte(), rand_byte());
      if (i == ncells / 2 && $urandom_range(0, 9) == 0) wait_idle();
    end
    if (ncells < cols * rows) return;
    for (int i = 0; i <= cols; i++) begin
      // an extra cell here only flushes
      if ($urandom_range(0, 9) == 0) send_word(KIND_CELL, $urandom, rand_byte(), rand_byte());
      else send_word(KIND_DRAIN, $urandom, rand_byte(), rand_byte());
    end
    if ($urandom_range(0, 3) == 0) send_word(KIND_DRAIN, $urandom, rand_byte(), rand_byte());
    frames_run++;
  endtask

  initial begin
    int cols, rows, reg_cols, reg_rows, scale, imw, imh;
    logic [31:0] thr;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    kind        = KIND_CELL;
    cell_score  = '0;
    root_width  = '0;
    root_height = '0;
    out_ready   = 1'b1;
    stall_mode  = 0;
    cycle_no    = 0;
    words_sent  = 0;
    burst_left  = 0;
    frames_run  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed 3x3 map: early drain, extreme scores and sizes, center peak, a tie.
    load_geometry(32'sd0, 3, 3, 256, 0, 0, 65535, 65535);
    send_word(KIND_DRAIN, 32'h1234_5678, 8'hFF, 8'hFF);
    send_word(KIND_CELL, 32'h8000_0000, 8'd0, 8'd0);
    send_word(KIND_CELL, 32'h0001_0000, 8'd255, 8'd0);
    send_word(KIND_CELL, 32'h0001_0000, 8'd0, 8'd255);
    send_word(KIND_CELL, 32'h0000_0001, 8'd1, 8'd1);
    send_word(KIND_CELL, 32'h7FFF_FFFF, 8'd255, 8'd255);
    send_word(KIND_CELL, 32'h0000_0002, 8'd4, 8'd3);
    send_word(KIND_CELL, 32'hFFFF_FFFF, 8'd7, 8'd9);
    send_word(KIND_CELL, 32'h0002_0000, 8'd2, 8'd2);
    send_word(KIND_CELL, 32'h0003_0000, 8'd3, 8'd3);
    send_word(KIND_CELL, 32'h7FFF_FFFF, 8'hAA, 8'h55);
    send_word(KIND_DRAIN, 32'h0, 8'h0, 8'h0);
    send_word(KIND_DRAIN, 32'h0, 8'h0, 8'h0);
    send_word(KIND_DRAIN, 32'h0, 8'h0, 8'h0);
    send_word(KIND_DRAIN, 32'h0, 8'h0, 8'h0);
    wait_idle();
    // Below-range geometry, lowest threshold, largest scale and pads.
    load_geometry(32'h8000_0000, 0, 0, 20'hFFFFF, 255, 255, 1, 1);
    run_frame(3, 1, 1 << 30);
    wait_idle();

    while (words_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: begin reg_cols = $urandom_range(0, 2); cols = 3; end
        1: begin reg_cols = 128; cols = 128; end
        2: begin reg_cols = $urandom_range(129, 255); cols = 128; end
        default: begin reg_cols = $urandom_range(3, 8); cols = reg_cols; end
      endcase
      case ($urandom_range(0, 7))
        0: begin reg_rows = 0; rows = 1; end
        default: begin reg_rows = $urandom_range(1, 6); rows = reg_rows; end
      endcase
      if (cols > 8) begin reg_rows = 1; rows = 1; end
      case ($urandom_range(0, 5))
        0: thr = 32'h8000_0000;
        1: thr = 32'h7FFF_FFFF;
        default: thr = $signed($urandom_range(0, 80)) - 40 <<< 12;
      endcase
      case ($urandom_range(0, 4))
        0: scale = 1;
        1: scale = 20'hFFFFF;
        2: scale = $urandom_range(1, 20'hFFFFF);
        default: scale = $urandom_range(128, 2048);
      endcase
      imw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 700);
      imh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 700);
      if ($urandom_range(0, 5) == 0) begin imw = 65535; imh = 65535; end
      load_geometry(thr, reg_cols, reg_rows, scale,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
                    imw, imh);
      repeat ($urandom_range(1, 4)) run_frame(cols, rows, 1 << 30);
      wait_idle();
      // At times a partial frame of the tallest maps; a map size write restarts it.
      if ($urandom_range(0, 11) == 0) begin
        write_reg(REG_MAP_COLUMNS, 3);
        write_reg(REG_MAP_ROWS, $urandom_range(0, 1) ? 4096 : 8191);
        run_frame(3, 4096, $urandom_range(20, 60));
        wait_idle();
      end
    end

    wait_idle();
    $display("sent %0d words over %0d full maps, checked %0d decisions, %0d with a box",
             words_sent, frames_run, decisions, peaks);
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, awaiting);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/smp_pkg.sv
design/smp_ram.sv
design/smp_front.sv
design/smp_queue.sv
design/smp_back.sv
design/score_map_peak_box_finder_top.sv
tb/smp_peak_checker.sv
tb/tb_top.sv
